/* sv/spom_pkg.sv */
`default_nettype none

package spom_pkg;

  // Store dimensions and element width.
  localparam int unsigned MaxRows   = 16;
  localparam int unsigned MaxCols   = 16;
  localparam int unsigned ElemWidth = 32;

  // Field widths of the channels and the configuration registers.
  localparam int unsigned RowW   = $clog2(MaxRows);
  localparam int unsigned ColW   = $clog2(MaxCols);
  localparam int unsigned DimW   = 5;
  localparam int unsigned AddrW  = RowW + ColW;
  localparam int unsigned Depth  = MaxRows * MaxCols;
  localparam int unsigned CountW = $clog2(Depth + 1);
  localparam int unsigned TotalW = 2 * DimW;

  // APB register map.
  localparam int unsigned PaddrW   = 3;
  localparam int unsigned PdataW   = 32;
  localparam logic        RegRows  = 1'b0;
  localparam logic        RegCols  = 1'b1;

  // Item kinds.
  localparam logic KindWrite = 1'b0;
  localparam logic KindFetch = 1'b1;

  typedef struct packed {
    logic [DimW-1:0] num_rows;
    logic [DimW-1:0] num_cols;
  } dims_t;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            last;
  } pos_t;

  // A dimension of zero counts as one; values above the store size saturate.
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] raw,
                                                input logic [DimW-1:0] max_dim);
    logic [DimW-1:0] res;
    res = raw;
    if (raw == '0) begin
      res = DimW'(1);
    end else if (raw > max_dim) begin
      res = max_dim;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* sv/spom_if.sv */
`default_nettype none

interface spom_in_if;
  import spom_pkg::*;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [RowW-1:0]             row_index;
  logic [ColW-1:0]             col_index;
  logic signed [ElemWidth-1:0] write_value;

  modport source (output valid, kind, row_index, col_index, write_value, input ready);
  modport sink   (input valid, kind, row_index, col_index, write_value, output ready);
endinterface

interface spom_out_if;
  import spom_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [ElemWidth-1:0] elem_value;
  logic [RowW-1:0]             elem_row;
  logic [ColW-1:0]             elem_col;
  logic                        is_last;

  modport source (output valid, elem_value, elem_row, elem_col, is_last, input ready);
  modport sink   (input valid, elem_value, elem_row, elem_col, is_last, output ready);
endinterface

`default_nettype wire

/* sv/spiral_order_matrix_reader_core.sv */
`default_nettype none

// The element RAM has one read port; the result of an accepted fetch is registered.
// Throughput: one transaction per cycle while the output stage is not stalled.
// Reset: asynchronous, active low; the dimensions return to 4 by 4 and the spiral restarts
// at the top-left corner. The element RAM is not cleared and holds undefined data until
// each entry is written.
module spiral_order_matrix_reader_core
  import spom_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  spom_in_if.sink                in_chan_i,
  spom_out_if.source             out_chan_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [PdataW-1:0] pwdata,
  output logic      [PdataW-1:0] prdata,
  output logic                   pready
);

  dims_t           dims, dims_next;
  pos_t            pos;
  logic            cfg_restart;
  logic            in_fire, wr_fire, fetch_fire;
  logic            out_valid_d, out_valid_q;
  logic [RowW-1:0] out_row_q;
  logic [ColW-1:0] out_col_q;
  logic            out_last_q;
  logic [ElemWidth-1:0] rdata;

  // The RAM read register, together with the coordinate registers below, forms the
  // output stage. A new transaction is taken whenever that stage is empty or is being
  // drained in the same cycle, so a waiting result never blocks the input side longer
  // than the consumer does.
  assign in_chan_i.ready = !out_valid_q || out_chan_o.ready;
  assign in_fire         = in_chan_i.valid && in_chan_i.ready;
  assign wr_fire         = in_fire && (in_chan_i.kind == KindWrite);
  assign fetch_fire      = in_fire && (in_chan_i.kind == KindFetch);

  spom_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .dims_o      (dims),
    .dims_next_o (dims_next),
    .restart_o   (cfg_restart)
  );

  // A register write or an element write both send the cursor back to the start.
  spom_cursor u_cursor (
    .clk_i,
    .rst_ni,
    .dims_i      (dims),
    .dims_next_i (dims_next),
    .restart_i   (cfg_restart || wr_fire),
    .fetch_i     (fetch_fire),
    .pos_o       (pos)
  );

  // Elements are stored row-major; with power-of-two store dimensions the address is
  // simply the row and column side by side. The read only fires on an accepted fetch,
  // so the read data holds while a result is stalled.
  spom_ram #(
    .Width (ElemWidth),
    .Depth (Depth)
  ) u_ram (
    .clk_i,
    .we_i    (wr_fire),
    .waddr_i ({in_chan_i.row_index, in_chan_i.col_index}),
    .wdata_i (in_chan_i.write_value),
    .re_i    (fetch_fire),
    .raddr_i ({pos.row, pos.col}),
    .rdata_o (rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (fetch_fire) begin
      out_valid_d = 1'b1;
    end else if (out_chan_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fetch_fire) begin
      out_row_q  <= pos.row;
      out_col_q  <= pos.col;
      out_last_q <= pos.last;
    end
  end

  assign out_chan_o.valid      = out_valid_q;
  assign out_chan_o.elem_value = rdata;
  assign out_chan_o.elem_row   = out_row_q;
  assign out_chan_o.elem_col   = out_col_q;
  assign out_chan_o.is_last    = out_last_q;

endmodule

`default_nettype wire

/* sv/spom_ram.sv */
`default_nettype none

module spom_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* sv/spom_cfg.sv */
`default_nettype none

module spom_cfg
  import spom_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [PdataW-1:0] pwdata,
  output logic      [PdataW-1:0] prdata,
  output logic                   pready,
  output dims_t                  dims_o,
  output dims_t                  dims_next_o,
  output logic                   restart_o
);

  dims_t dims_d, dims_q;
  logic  wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    dims_d = dims_q;
    if (wr_en) begin
      unique case (paddr[2])
        RegRows: dims_d.num_rows = pwdata[DimW-1:0];
        RegCols: dims_d.num_cols = pwdata[DimW-1:0];
        default: dims_d = dims_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q.num_rows <= DimW'(4);
      dims_q.num_cols <= DimW'(4);
    end else begin
      dims_q <= dims_d;
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegRows: prdata = PdataW'(dims_q.num_rows);
      RegCols: prdata = PdataW'(dims_q.num_cols);
      default: prdata = '0;
    endcase
  end

  assign dims_o      = dims_q;
  assign dims_next_o = dims_d;
  assign restart_o   = wr_en;

endmodule

`default_nettype wire

/* sv/spom_cursor.sv */
`default_nettype none

module spom_cursor
  import spom_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire dims_t dims_i,
  input  wire dims_t dims_next_i,
  input  wire logic  restart_i,
  input  wire logic  fetch_i,
  output pos_t       pos_o
);

  localparam logic [1:0] PhTop    = 2'd0;
  localparam logic [1:0] PhRight  = 2'd1;
  localparam logic [1:0] PhBottom = 2'd2;
  localparam logic [1:0] PhLeft   = 2'd3;

  logic [1:0]        phase_d, phase_q;
  logic [RowW-1:0]   top_d, top_q, bottom_d, bottom_q, row_d, row_q;
  logic [ColW-1:0]   left_d, left_q, right_d, right_q, col_d, col_q;
  logic [CountW-1:0] count_d, count_q;
  logic [DimW-1:0]   rows_c, cols_c, rows_n, cols_n;
  logic [TotalW-1:0] total;
  logic              last;

  assign rows_c = clamp_dim(dims_i.num_rows, DimW'(MaxRows));
  assign cols_c = clamp_dim(dims_i.num_cols, DimW'(MaxCols));
  assign rows_n = clamp_dim(dims_next_i.num_rows, DimW'(MaxRows));
  assign cols_n = clamp_dim(dims_next_i.num_cols, DimW'(MaxCols));
  assign total  = TotalW'(rows_c) * TotalW'(cols_c);
  assign last   = (TotalW'(count_q) + TotalW'(1)) >= total;

  always_comb begin
    phase_d  = phase_q;
    top_d    = top_q;
    bottom_d = bottom_q;
    left_d   = left_q;
    right_d  = right_q;
    row_d    = row_q;
    col_d    = col_q;
    count_d  = count_q;
    if (restart_i || (fetch_i && last)) begin
      // Restart from the top-left corner with the bounds of the new dimensions.
      phase_d  = PhTop;
      top_d    = '0;
      left_d   = '0;
      bottom_d = RowW'(rows_n - DimW'(1));
      right_d  = ColW'(cols_n - DimW'(1));
      row_d    = '0;
      col_d    = '0;
      count_d  = '0;
    end else if (fetch_i) begin
      count_d = count_q + CountW'(1);
      unique case (phase_q)
        PhTop: begin
          if (col_q < right_q) begin
            col_d = col_q + ColW'(1);
          end else begin
            top_d   = top_q + RowW'(1);
            phase_d = PhRight;
            row_d   = top_q + RowW'(1);
            col_d   = right_q;
          end
        end
        PhRight: begin
          if (row_q < bottom_q) begin
            row_d = row_q + RowW'(1);
          end else begin
            right_d = right_q - ColW'(1);
            phase_d = PhBottom;
            row_d   = bottom_q;
            col_d   = right_q - ColW'(1);
          end
        end
        PhBottom: begin
          if (col_q > left_q) begin
            col_d = col_q - ColW'(1);
          end else begin
            bottom_d = bottom_q - RowW'(1);
            phase_d  = PhLeft;
            row_d    = bottom_q - RowW'(1);
            col_d    = left_q;
          end
        end
        PhLeft: begin
          if (row_q > top_q) begin
            row_d = row_q - RowW'(1);
          end else begin
            left_d  = left_q + ColW'(1);
            phase_d = PhTop;
            row_d   = top_q;
            col_d   = left_q + ColW'(1);
          end
        end
        default: phase_d = PhTop;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhTop;
      top_q    <= '0;
      left_q   <= '0;
      bottom_q <= RowW'(3);
      right_q  <= ColW'(3);
      row_q    <= '0;
      col_q    <= '0;
      count_q  <= '0;
    end else begin
      phase_q  <= phase_d;
      top_q    <= top_d;
      left_q   <= left_d;
      bottom_q <= bottom_d;
      right_q  <= right_d;
      row_q    <= row_d;
      col_q    <= col_d;
      count_q  <= count_d;
    end
  end

  assign pos_o.row  = row_q;
  assign pos_o.col  = col_q;
  assign pos_o.last = last;

endmodule

`default_nettype wire
